### src/pidc_pkg.sv
// Shared types and constants for the PID step block.
// Used by pidc_mul and pid_step_with_integral_clamp; depends on nothing.
package pidc_pkg;

    // Q16.16 word and fraction
    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int UREG_W  = 31;

    // Digit-serial multiplier geometry
    localparam int DIGIT_W = 4;
    localparam int DIGITS  = DATA_W / DIGIT_W;
    localparam int CNT_W   = $clog2(DIGITS);
    localparam int MA_W    = DATA_W + 1;                // multiplicand, signed
    localparam int ACC_W   = MA_W + DIGIT_W + 2;        // running high part
    localparam int PROD_W  = 2 * DATA_W + 1 - FRAC_W;   // floor(a*b / 2^16)

    // Sum of three scaled products
    localparam int SUM_W   = PROD_W + 1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P       = 3'd0,
        REG_GAIN_I       = 3'd1,
        REG_GAIN_D       = 3'd2,
        REG_WINDUP_LIMIT = 3'd3,
        REG_STEP_TIME    = 3'd4,
        REG_STEP_RATE    = 3'd5
    } t_cfg_idx;

    // Reset values of the configuration registers
    localparam logic [UREG_W-1:0] WINDUP_LIMIT_RST = 31'd65536;
    localparam logic [UREG_W-1:0] STEP_TIME_RST    = 31'd1311;
    localparam logic [UREG_W-1:0] STEP_RATE_RST    = 31'd3276800;

    // Request to the shared multiplier
    typedef struct packed {
        logic                     start;
        logic signed [MA_W-1:0]   a;
        logic signed [DATA_W-1:0] b;
    } t_mul_req;

    // Status and result from the shared multiplier
    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] prod;
    } t_mul_rsp;

endpackage

### src/pidc_mul.sv
// Digit-serial signed multiplier, 4 multiplier bits per cycle.
// Returns floor(a*b / 2^16) exactly; depends on pidc_pkg.
module pidc_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pidc_pkg::t_mul_req i_req,
    output pidc_pkg::t_mul_rsp o_rsp
);
    import pidc_pkg::*;

    logic signed [MA_W-1:0]    r_a;
    logic        [DATA_W-1:0]  r_b, n_b;
    logic signed [ACC_W-1:0]   r_hi, n_hi;
    logic        [DATA_W-1:0]  r_lo, n_lo;
    logic        [CNT_W-1:0]   r_cnt;
    logic                      r_busy, r_done;

    logic                      last_digit;
    logic signed [DIGIT_W:0]   digit;
    logic signed [ACC_W-1:0]   part, total;

    // One digit step: add a*digit to the high part, move 4 bits down
    always_comb begin
        last_digit = (r_cnt == CNT_W'(DIGITS - 1));
        // top digit of b carries the sign
        digit = last_digit ? {r_b[DIGIT_W-1], r_b[DIGIT_W-1:0]}
                           : {1'b0, r_b[DIGIT_W-1:0]};
        part  = ACC_W'(r_a) * ACC_W'(digit);
        total = r_hi + part;
        n_hi  = total >>> DIGIT_W;
        n_lo  = {total[DIGIT_W-1:0], r_lo[DATA_W-1:DIGIT_W]};
        n_b   = r_b >> DIGIT_W;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (last_digit) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Operand and accumulator shift registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a  <= i_req.a;
            r_b  <= i_req.b;
            r_hi <= '0;
            r_lo <= '0;
        end else if (r_busy) begin
            r_b  <= n_b;
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    // High part holds product >> 32; drop the 16 lowest bits for the floor
    assign o_rsp.done = r_done;
    assign o_rsp.prod = {r_hi[MA_W-1:0], r_lo[DATA_W-1:FRAC_W]};

endmodule

### src/pid_step_with_integral_clamp.sv
// PID step with integral clamp: sequencer, state, configuration, output register.
// Depends on pidc_pkg and pidc_mul.
//
// One item (setpoint and measurement, signed Q16.16) yields one drive value.
// All five products (error*dt, delta*rate and the three gain terms) run in turn
// through one digit-serial multiplier that retires 4 bits per cycle. When the
// output register is free, an item's result is loaded into it; the next item
// is accepted in the cycle after that, even while the result still waits on
// the output. Configuration writes are always taken (ready held high) and
// should be made while idle.
module pid_step_with_integral_clamp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [pidc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pidc_pkg::DATA_W-1:0]    i_cfg_data,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [2*pidc_pkg::DATA_W-1:0] s_axis_tdata, // [31:0] target_value, [63:32] sensed_value
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [pidc_pkg::DATA_W-1:0]   m_axis_tdata  // [31:0] drive_value
);
    import pidc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INT  = 6'b000010,
        S_DER  = 6'b000100,
        S_PRP  = 6'b001000,
        S_ITG  = 6'b010000,
        S_DRV  = 6'b100000
    } t_state;

    localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    t_state r_state, n_state;

    logic signed [DATA_W-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic        [UREG_W-1:0] r_windup_limit, r_step_time, r_step_rate;

    logic signed [DATA_W-1:0] r_integ, r_last_err, r_err, r_deriv;
    logic signed [DATA_W:0]   r_diff;
    logic signed [SUM_W-1:0]  r_sum;
    logic        [DATA_W-1:0] r_out_data;
    logic                     r_out_valid;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    logic                     in_fire, out_free, out_load;
    logic signed [DATA_W-1:0] tgt, meas, err_now;
    logic signed [DATA_W:0]   err_wide;
    logic signed [SUM_W-1:0]  integ_wide, lim_pos, lim_neg, sum_total;
    logic signed [DATA_W-1:0] integ_clamped, deriv_sat, drive_sat;

    pidc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // Handshakes
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Error, saturated to 32 bits
    always_comb begin
        tgt      = s_axis_tdata[DATA_W-1:0];
        meas     = s_axis_tdata[2*DATA_W-1:DATA_W];
        err_wide = (DATA_W+1)'(tgt) - (DATA_W+1)'(meas);
        if (err_wide > (DATA_W+1)'(S32_MAX))      err_now = S32_MAX;
        else if (err_wide < (DATA_W+1)'(S32_MIN)) err_now = S32_MIN;
        else                                      err_now = err_wide[DATA_W-1:0];
    end

    // Integral update with clamp to +/- windup_limit
    always_comb begin
        integ_wide = SUM_W'(r_integ) + SUM_W'(mul_rsp.prod);
        lim_pos    = SUM_W'({1'b0, r_windup_limit});
        lim_neg    = -lim_pos;
        if (integ_wide > lim_pos)      integ_clamped = lim_pos[DATA_W-1:0];
        else if (integ_wide < lim_neg) integ_clamped = lim_neg[DATA_W-1:0];
        else                           integ_clamped = integ_wide[DATA_W-1:0];
    end

    // Derivative and final sum saturation
    always_comb begin
        if (mul_rsp.prod > PROD_W'(S32_MAX))      deriv_sat = S32_MAX;
        else if (mul_rsp.prod < PROD_W'(S32_MIN)) deriv_sat = S32_MIN;
        else                                      deriv_sat = mul_rsp.prod[DATA_W-1:0];
        sum_total = r_sum + SUM_W'(mul_rsp.prod);
        if (sum_total > SUM_W'(S32_MAX))          drive_sat = S32_MAX;
        else if (sum_total < SUM_W'(S32_MIN))     drive_sat = S32_MIN;
        else                                      drive_sat = sum_total[DATA_W-1:0];
    end

    // Sequencer: one product per state, next product launched as one finishes
    always_comb begin
        n_state       = r_state;
        mul_req.start = 1'b0;
        mul_req.a     = MA_W'(r_err);
        mul_req.b     = {1'b0, r_step_time};
        out_load      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                mul_req.a = MA_W'(err_now);
                if (in_fire) begin
                    mul_req.start = 1'b1;
                    n_state       = S_INT;
                end
            end
            S_INT: begin
                mul_req.a = r_diff;
                mul_req.b = {1'b0, r_step_rate};
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    n_state       = S_DER;
                end
            end
            S_DER: begin
                mul_req.a = MA_W'(r_err);
                mul_req.b = r_gain_p;
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    n_state       = S_PRP;
                end
            end
            S_PRP: begin
                mul_req.a = MA_W'(r_integ);
                mul_req.b = r_gain_i;
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    n_state       = S_ITG;
                end
            end
            S_ITG: begin
                mul_req.a = MA_W'(r_deriv);
                mul_req.b = r_gain_d;
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    n_state       = S_DRV;
                end
            end
            S_DRV: begin
                if (mul_rsp.done && out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p       <= '0;
            r_gain_i       <= '0;
            r_gain_d       <= '0;
            r_windup_limit <= WINDUP_LIMIT_RST;
            r_step_time    <= STEP_TIME_RST;
            r_step_rate    <= STEP_RATE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_GAIN_P:       r_gain_p       <= i_cfg_data;
                REG_GAIN_I:       r_gain_i       <= i_cfg_data;
                REG_GAIN_D:       r_gain_d       <= i_cfg_data;
                REG_WINDUP_LIMIT: r_windup_limit <= i_cfg_data[UREG_W-1:0];
                REG_STEP_TIME:    r_step_time    <= i_cfg_data[UREG_W-1:0];
                REG_STEP_RATE:    r_step_rate    <= i_cfg_data[UREG_W-1:0];
                default: ;
            endcase
        end
    end

    // Controller state: integral and previous error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_last_err <= '0;
        end else begin
            if (r_state == S_INT && mul_rsp.done) r_integ    <= integ_clamped;
            if (r_state == S_DER && mul_rsp.done) r_last_err <= r_err;
        end
    end

    // Per-item working registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_err  <= err_now;
            r_diff <= (DATA_W+1)'(err_now) - (DATA_W+1)'(r_last_err);
        end
        if (r_state == S_DER && mul_rsp.done) r_deriv <= deriv_sat;
        if (r_state == S_PRP && mul_rsp.done) r_sum   <= SUM_W'(mul_rsp.prod);
        if (r_state == S_ITG && mul_rsp.done) r_sum   <= sum_total;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) r_out_data <= drive_sat;
    end

endmodule

### verif/tb_top.sv
// Self-checking testbench for pid_step_with_integral_clamp: sample stream in,
// drive value stream out, checked against a Q16.16 PID predictor kept here.
// Depends on pidc_pkg and the RTL under src/.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pidc_pkg::*;

    localparam int     HALF_PERIOD  = 5;
    localparam int     RESET_CYCLES = 6;
    localparam int     DRAIN_CYCLES = 60;
    localparam int     WDOG_LIMIT   = 5000;
    localparam int     MAX_REPORTS  = 10;
    localparam int     RAND_PHASES  = 8;
    localparam int     PHASE_ITEMS  = 250;
    localparam longint S32_MAX      = 64'sd2147483647;
    localparam longint S32_MIN      = -64'sd2147483648;

    localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN  = 32'h8000_0000;
    localparam logic [31:0] Q_ONE  = 32'h0001_0000;
    localparam logic [31:0] Q_MONE = 32'hFFFF_0000;

    // Indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    // DUT ports, every input known from time zero
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [DATA_W-1:0]    i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [2*DATA_W-1:0]  s_axis_tdata  = '0;  // [31:0] target_value, [63:32] sensed_value
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [DATA_W-1:0]    m_axis_tdata;        // [31:0] drive_value

    // Controller copy: configuration and loop state
    longint kp_q      = 0;
    longint ki_q      = 0;
    longint kd_q      = 0;
    longint clamp_q   = 65536;
    longint dt_q      = 1311;
    longint rate_q    = 3276800;
    longint integ_acc = 0;
    longint err_prev  = 0;

    logic [2*DATA_W-1:0] sample_q[$];     // samples waiting to be sent
    logic [DATA_W-1:0]   drive_exp_q[$];  // predicted drive values
    int                  mismatch_cnt = 0;

    pid_step_with_integral_clamp u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic longint sat_s32(longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    // One control tick: error, clamped integral, derivative, saturated sum.
    // Every product fits in 64 bits; >>> on longint floors.
    function automatic logic [DATA_W-1:0] pid_drive_predict(logic [DATA_W-1:0] tgt_raw,
                                                            logic [DATA_W-1:0] sns_raw);
        longint tgt;
        longint sns;
        longint err;
        longint integ;
        longint deriv;
        longint sum;
        tgt   = longint'($signed(tgt_raw));
        sns   = longint'($signed(sns_raw));
        err   = sat_s32(tgt - sns);
        integ = integ_acc + ((err * dt_q) >>> FRAC_W);
        if (integ > clamp_q)  integ = clamp_q;
        if (integ < -clamp_q) integ = -clamp_q;
        integ_acc = integ;
        deriv    = sat_s32(((err - err_prev) * rate_q) >>> FRAC_W);
        err_prev = err;
        sum = ((kp_q * err) >>> FRAC_W) + ((ki_q * integ) >>> FRAC_W)
            + ((kd_q * deriv) >>> FRAC_W);
        sum = sat_s32(sum);
        return sum[DATA_W-1:0];
    endfunction

    // Register write; the local copy follows on the accepting edge
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_GAIN_P:       kp_q    = longint'($signed(data));
            REG_GAIN_I:       ki_q    = longint'($signed(data));
            REG_GAIN_D:       kd_q    = longint'($signed(data));
            REG_WINDUP_LIMIT: clamp_q = longint'(data[UREG_W-1:0]);
            REG_STEP_TIME:    dt_q    = longint'(data[UREG_W-1:0]);
            REG_STEP_RATE:    rate_q  = longint'(data[UREG_W-1:0]);
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_pair(logic [DATA_W-1:0] tgt, logic [DATA_W-1:0] sns);
        sample_q.push_back({sns, tgt});
    endtask

    // Block idle: everything sent, every drive value back, pipeline flushed
    task automatic wait_drained();
        do @(negedge i_clk);
        while (sample_q.size() != 0 || s_axis_tvalid || drive_exp_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] rand_gain();
        case ($urandom_range(0, 9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return 32'h0;
            default: return $urandom_range(0, 8 * 65536) - 4 * 65536;
        endcase
    endfunction

    // Unsigned register value; bit 31 is random and must be dropped
    function automatic logic [DATA_W-1:0] rand_ureg(int hi);
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'h0;
            1:       v = 32'h1;
            2:       v = Q_MAX;
            default: v = $urandom_range(1, hi);
        endcase
        v[DATA_W-1] = 1'($urandom_range(0, 1));
        return v;
    endfunction

    // Sample value: mostly random magnitudes, some field extremes
    function automatic logic [DATA_W-1:0] rand_sample_word();
        logic signed [DATA_W-1:0] r;
        case ($urandom_range(0, 11))
            0:       r = Q_MAX;
            1:       r = Q_MIN;
            2:       r = 32'h0;
            default: begin
                r = $urandom;
                r = r >>> $urandom_range(0, 31);
            end
        endcase
        return r;
    endfunction

    // Sender: bursts of items with random gaps, valid held until accepted
    int burst_left = 0;
    int gap_left   = 0;
    always @(posedge i_clk) begin
        logic                send;
        logic [2*DATA_W-1:0] word;
        send = 1'b0;
        word = '0;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                drive_exp_q.push_back(pid_drive_predict(s_axis_tdata[DATA_W-1:0],
                                                        s_axis_tdata[2*DATA_W-1:DATA_W]));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (sample_q.size() > 0) begin
                    send = 1'b1;
                    word = sample_q.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                    end else begin
                        burst_left--;
                    end
                end
                s_axis_tvalid <= send;
                if (send) begin
                    s_axis_tdata <= word;
                end
            end
        end
    end

    // Receiver: stall pattern switches between randomly chosen modes
    int rx_cyc     = 0;
    int stall_mode = 0;
    always @(posedge i_clk) begin
        logic [DATA_W-1:0] want;
        logic              rdy;
        want = '0;
        rdy  = 1'b1;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (drive_exp_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("%0t: drive_value %h arrived with none predicted",
                                 $realtime, m_axis_tdata);
                end else begin
                    want = drive_exp_q.pop_front();
                    if (m_axis_tdata !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS)
                            $display("%0t: drive_value expected %h got %h",
                                     $realtime, want, m_axis_tdata);
                    end
                end
            end
            rx_cyc++;
            if (rx_cyc % 512 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       rdy = 1'b1;
                1:       rdy = ($urandom_range(0, 3) != 0);
                2:       rdy = ((rx_cyc % 23) < 15);
                default: rdy = ($urandom_range(0, 7) == 0);
            endcase
            m_axis_tready <= rdy;
        end
    end

    // Watchdog on cycles with no handshake of any kind
    int idle_cyc = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cyc <= 0;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
        if (idle_cyc >= WDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Phases: directed corners, then random configurations with random traffic
    initial begin
        int ph;
        int n;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Unit gains, reset loop timing: error saturation, integral clamp
        cfg_write(REG_GAIN_P, Q_ONE);
        cfg_write(REG_GAIN_I, Q_ONE);
        cfg_write(REG_GAIN_D, Q_ONE);
        @(negedge i_clk);
        push_pair(32'h0, 32'h0);
        push_pair(Q_MAX, Q_MIN);
        push_pair(Q_MAX, Q_MIN);
        push_pair(Q_MIN, Q_MAX);
        push_pair(Q_MAX, Q_MAX);
        push_pair(Q_MIN, Q_MIN);
        push_pair(32'h1, 32'h0);
        push_pair(32'hFFFF_FFFF, 32'h0);
        push_pair(32'h0, Q_MIN);
        wait_drained();

        // Extreme gains and timing: derivative and output saturation
        cfg_write(REG_GAIN_P, Q_MAX);
        cfg_write(REG_GAIN_I, Q_MIN);
        cfg_write(REG_GAIN_D, Q_MAX);
        cfg_write(REG_WINDUP_LIMIT, 32'hFFFF_FFFF);
        cfg_write(REG_STEP_TIME, 32'hFFFF_FFFF);
        cfg_write(REG_STEP_RATE, Q_MAX);
        @(negedge i_clk);
        push_pair(Q_MAX, Q_MIN);
        push_pair(Q_MAX, Q_MIN);
        push_pair(Q_MIN, Q_MAX);
        push_pair(32'h0, 32'h0);
        push_pair(Q_ONE, 32'h0);
        push_pair(Q_MONE, Q_ONE);
        wait_drained();

        // Zero limit, zero dt, zero rate, writes to unused indexes
        cfg_write(REG_GAIN_P, Q_MONE);
        cfg_write(REG_GAIN_I, Q_MONE);
        cfg_write(REG_GAIN_D, Q_MONE);
        cfg_write(REG_WINDUP_LIMIT, 32'h0);
        cfg_write(REG_STEP_TIME, 32'h0);
        cfg_write(REG_STEP_RATE, 32'h0);
        cfg_write(REG_SPARE_6, $urandom);
        cfg_write(REG_SPARE_7, $urandom);
        @(negedge i_clk);
        push_pair(Q_MAX, Q_MIN);
        push_pair(32'd123456, -32'sd654321);
        push_pair(32'h0, 32'h0);
        push_pair(Q_MIN, Q_ONE);
        wait_drained();

        // Random configurations; each phase ends with the block fully drained
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            cfg_write(REG_GAIN_P, rand_gain());
            cfg_write(REG_GAIN_I, rand_gain());
            cfg_write(REG_GAIN_D, rand_gain());
            cfg_write(REG_WINDUP_LIMIT, rand_ureg(64 * 65536));
            cfg_write(REG_STEP_TIME, rand_ureg(65536));
            cfg_write(REG_STEP_RATE, rand_ureg(1000 * 65536));
            if ($urandom_range(0, 1) == 1)
                cfg_write(($urandom_range(0, 1) == 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom);
            @(negedge i_clk);
            for (n = 0; n < PHASE_ITEMS; n++)
                push_pair(rand_sample_word(), rand_sample_word());
            wait_drained();
        end

        mismatch_cnt += drive_exp_q.size();
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
